// ===== sv/oidca_pkg.sv =====
// Shared types and constants for the object identifier arc decoder.
package oidca_pkg;

  localparam int ArcBits       = 32;
  localparam int MaxSubidBytes = 6;
  localparam int CntBits       = 3;
  localparam int QueueDepth    = 4;
  localparam int QueuePtrBits  = 2;

  localparam logic [6:0] PayloadMask = 7'h7f;
  localparam logic [ArcBits-1:0] ArcSplit1 = ArcBits'(40);
  localparam logic [ArcBits-1:0] ArcSplit2 = ArcBits'(80);

  localparam logic [1:0] ST_ARC       = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;
  localparam logic [1:0] ST_BAD_FIRST = 2'd3;

  typedef struct packed {
    logic [ArcBits-1:0] arc_value;
    logic [1:0]         status;
    logic               arc_ends_oid;
    logic               run_last;
  } res_t;

  // Results of one request, in order; n_res is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] n_res;
    res_t       res0;
    res_t       res1;
  } push_t;

endpackage

// ===== sv/oidca_decode.sv =====
// Subidentifier accumulator and arc splitter: decodes one content byte per request.
module oidca_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           content_byte,
  input  logic                 oid_start,
  input  logic                 oid_final,
  output oidca_pkg::push_t     push
);
  import oidca_pkg::*;

  logic [ArcBits-1:0] acc_r, acc_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CntBits-1:0] bytes_r, bytes_nxt;
  logic               first_r, first_nxt;
  logic               err_r, err_nxt;

  logic [ArcBits-1:0] acc_in, acc_sh, v;
  logic               ovf_in, bytes_ovf, first_in, err_in, cont;
  logic [CntBits-1:0] bytes_in, cnt;

  always_comb begin
    // A start mark discards whatever the previous OID left behind.
    acc_in   = oid_start ? '0   : acc_r;
    ovf_in   = oid_start ? 1'b0 : ovf_r;
    bytes_in = oid_start ? '0   : bytes_r;
    first_in = oid_start ? 1'b1 : first_r;
    err_in   = oid_start ? 1'b0 : err_r;

    cont      = content_byte[7];
    bytes_ovf = ovf_in | (acc_in[ArcBits-1:ArcBits-7] != '0);
    acc_sh    = {acc_in[ArcBits-8:0], content_byte[6:0] & PayloadMask};
    cnt       = bytes_in + CntBits'(1);
    v         = acc_sh;

    acc_nxt   = acc_in;
    ovf_nxt   = ovf_in;
    bytes_nxt = bytes_in;
    first_nxt = first_in;
    err_nxt   = err_in;
    push      = '0;

    if (err_in) begin
      // Drop the rest of a failed OID up to its final byte.
      if (oid_final) begin
        err_nxt   = 1'b0;
        acc_nxt   = '0;
        ovf_nxt   = 1'b0;
        bytes_nxt = '0;
        first_nxt = 1'b1;
      end
    end else if (cont && (cnt < CntBits'(MaxSubidBytes)) && !oid_final) begin
      acc_nxt   = acc_sh;
      ovf_nxt   = bytes_ovf;
      bytes_nxt = cnt;
    end else begin
      // Every remaining path ends the subidentifier; default to a clear.
      acc_nxt   = '0;
      ovf_nxt   = 1'b0;
      bytes_nxt = '0;
      push.n_res = 2'd1;
      if (cont || bytes_ovf || (first_in && (cnt > CntBits'(1)) && (v < ArcSplit2))) begin
        first_nxt = 1'b1;
        err_nxt   = !oid_final;
        push.res0.arc_value    = '0;
        push.res0.arc_ends_oid = 1'b1;
        push.res0.run_last     = 1'b1;
        if (cont)
          push.res0.status = (cnt >= CntBits'(MaxSubidBytes) || bytes_ovf) ?
                             ST_MALFORMED : ST_TRUNCATED;
        else if (bytes_ovf)
          push.res0.status = ST_MALFORMED;
        else
          push.res0.status = ST_BAD_FIRST;
      end else if (first_in) begin
        push.n_res = 2'd2;
        push.res0.status       = ST_ARC;
        push.res0.arc_ends_oid = 1'b0;
        push.res0.run_last     = 1'b0;
        push.res1.status       = ST_ARC;
        push.res1.arc_ends_oid = oid_final;
        push.res1.run_last     = 1'b1;
        if (v < ArcSplit1) begin
          push.res0.arc_value = ArcBits'(0);
          push.res1.arc_value = v;
        end else if (v < ArcSplit2) begin
          push.res0.arc_value = ArcBits'(1);
          push.res1.arc_value = v - ArcSplit1;
        end else begin
          push.res0.arc_value = ArcBits'(2);
          push.res1.arc_value = v - ArcSplit2;
        end
        first_nxt = oid_final;
      end else begin
        push.res0.arc_value    = v;
        push.res0.status       = ST_ARC;
        push.res0.arc_ends_oid = oid_final;
        push.res0.run_last     = 1'b1;
        first_nxt = oid_final;
      end
    end
    if (!accept)
      push.n_res = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      bytes_r <= '0;
      first_r <= 1'b1;
      err_r   <= 1'b0;
    end else if (accept) begin
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      bytes_r <= bytes_nxt;
      first_r <= first_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ===== sv/oidca_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per cycle while out_ready is high.
module oidca_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  oidca_pkg::push_t     push,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output oidca_pkg::res_t      out_res
);
  import oidca_pkg::*;

  res_t                    mem_r [QueueDepth];
  logic [QueuePtrBits-1:0] wr_ptr_r, rd_ptr_r;
  logic [QueuePtrBits:0]   count_r, count_nxt;
  logic                    pop;
  logic [QueuePtrBits-1:0] wr_ptr1;

  assign out_valid = (count_r != '0);
  assign room      = (count_r <= (QueuePtrBits+1)'(QueueDepth - 2));
  assign pop       = out_valid & out_ready;
  assign out_res   = mem_r[rd_ptr_r];
  assign wr_ptr1   = wr_ptr_r + QueuePtrBits'(1);
  assign count_nxt = count_r + (QueuePtrBits+1)'(push.n_res) - (QueuePtrBits+1)'(pop);

  always_ff @(posedge clk) begin
    if (push.n_res != 2'd0)
      mem_r[wr_ptr_r] <= push.res0;
    if (push.n_res == 2'd2)
      mem_r[wr_ptr1] <= push.res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QueuePtrBits'(push.n_res);
      if (pop)
        rd_ptr_r <= rd_ptr_r + QueuePtrBits'(1);
      count_r <= count_nxt;
    end
  end

endmodule

// ===== sv/oid_content_arc_decoder.sv =====
// Decodes the content bytes of a DER object identifier into arc numbers at one byte per
// cycle while in_tready is high. A byte is decoded in the cycle it is accepted and its
// results enter a four-entry queue; the first arc of a result shows on the output once the
// queue registers hold it and earlier results have been taken. The first subidentifier
// yields two arcs, every later one yields one, and an error yields a single status result
// with arc value zero that ends the OID. The output drains one result per cycle while
// out_tready is high; in_tready drops only when fewer than two queue entries are free.
module oid_content_arc_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] content_byte
  input  logic [0:0]  in_tuser,   // [0] oid_start
  input  logic        in_tlast,   // oid_final
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] arc_value
  output logic [2:0]  out_tuser,  // [1:0] status, [2] run_last
  output logic        out_tlast   // arc_ends_oid
);
  import oidca_pkg::*;

  push_t push;
  res_t  head;
  logic  accept;

  assign accept = in_tvalid & in_tready;

  oidca_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .content_byte (in_tdata),
    .oid_start    (in_tuser[0]),
    .oid_final    (in_tlast),
    .push         (push)
  );

  oidca_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (head)
  );

  assign out_tdata = head.arc_value;
  assign out_tuser = {head.run_last, head.status};
  assign out_tlast = head.arc_ends_oid;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result queue not empty after reset");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] != ST_ARC) |-> (out_tdata == '0) && out_tlast && out_tuser[2])
    else $error("error result must carry zero arc and end the OID");

  a_split_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |-> (out_tuser[1:0] == ST_ARC) && !out_tlast
                                    && (out_tdata < 32'd3))
    else $error("leading arc of a split must be 0, 1 or 2 and not end the OID");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the object identifier arc decoder.
`timescale 1ns / 100ps

module tb;
  import oidca_pkg::*;

  localparam int ClkPeriod    = 10;
  localparam int ResetCycles  = 12;
  localparam int TargetBytes  = 1300;
  localparam int DrainCycles  = 20;
  localparam int CycleLimit   = 1000000;

  // Predicts the arcs of each decoded content byte and checks them in order.
  class oid_arc_scoreboard;
    res_t               expected_arcs[$];
    logic [ArcBits-1:0] arc_acc;
    bit                 acc_overflow;
    logic [CntBits-1:0] subid_len;
    bit                 want_first;
    bit                 skip_rest;
    int                 errors;
    int                 checked;
    int                 status_seen[4];

    function new();
      clear_oid();
    endfunction

    function void clear_oid();
      arc_acc      = '0;
      acc_overflow = 1'b0;
      subid_len    = '0;
      want_first   = 1'b1;
      skip_rest    = 1'b0;
    endfunction

    function void push_arc(logic [ArcBits-1:0] arc, logic [1:0] st, bit ends, bit last);
      res_t r;
      r.arc_value    = arc;
      r.status       = st;
      r.arc_ends_oid = ends;
      r.run_last     = last;
      expected_arcs.push_back(r);
    endfunction

    // An error ends the OID; drop the rest of it unless this byte was its last.
    function void push_error(logic [1:0] st, bit fin);
      push_arc('0, st, 1'b1, 1'b1);
      clear_oid();
      skip_rest = !fin;
    endfunction

    // Returns 1 when the byte was decoded, 0 when it was skipped after an error.
    function bit note_byte(logic [7:0] b, bit st, bit fin);
      logic [CntBits-1:0] len;
      logic [ArcBits-1:0] v;
      if (st) clear_oid();
      if (skip_rest) begin
        if (fin) clear_oid();
        return 1'b0;
      end
      if (arc_acc[ArcBits-1 -: 7] != 0) acc_overflow = 1'b1;
      arc_acc = {arc_acc[ArcBits-8:0], b[6:0]};
      len = subid_len + 1'b1;
      if (b[7]) begin
        if (len >= MaxSubidBytes) push_error(ST_MALFORMED, fin);
        else if (fin) push_error(acc_overflow ? ST_MALFORMED : ST_TRUNCATED, fin);
        else subid_len = len;
        return 1'b1;
      end
      if (acc_overflow) begin
        push_error(ST_MALFORMED, fin);
        return 1'b1;
      end
      v = arc_acc;
      if (want_first) begin
        if (len > 1 && v < ArcSplit2) begin
          push_error(ST_BAD_FIRST, fin);
          return 1'b1;
        end
        if (v < ArcSplit1) begin
          push_arc(0, ST_ARC, 1'b0, 1'b0);
          push_arc(v, ST_ARC, fin, 1'b1);
        end else if (v < ArcSplit2) begin
          push_arc(1, ST_ARC, 1'b0, 1'b0);
          push_arc(v - ArcSplit1, ST_ARC, fin, 1'b1);
        end else begin
          push_arc(2, ST_ARC, 1'b0, 1'b0);
          push_arc(v - ArcSplit2, ST_ARC, fin, 1'b1);
        end
        want_first = 1'b0;
      end else begin
        push_arc(v, ST_ARC, fin, 1'b1);
      end
      arc_acc   = '0;
      subid_len = '0;
      if (fin) clear_oid();
      return 1'b1;
    endfunction

    function int pending();
      return expected_arcs.size();
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", what);
    endtask

    task check_arc(logic [31:0] arc, logic [1:0] st, logic ends, logic last);
      res_t want;
      if (expected_arcs.size() == 0) begin
        report($sformatf("unexpected result arc=%0d status=%0d ends=%0d last=%0d",
                         arc, st, ends, last));
        return;
      end
      want = expected_arcs.pop_front();
      checked++;
      status_seen[want.status]++;
      if (arc !== want.arc_value)
        report($sformatf("result %0d: arc %0d, expected %0d", checked, arc, want.arc_value));
      if (st !== want.status)
        report($sformatf("result %0d: status %0d, expected %0d", checked, st, want.status));
      if (ends !== want.arc_ends_oid)
        report($sformatf("result %0d: ends_oid %0d, expected %0d",
                         checked, ends, want.arc_ends_oid));
      if (last !== want.run_last)
        report($sformatf("result %0d: run_last %0d, expected %0d",
                         checked, last, want.run_last));
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  oid_arc_scoreboard sb = new();
  logic [7:0] oid_bytes[$];
  bit         in_steady;
  int         sent_items;
  int         decoded_items;
  int         cycle_count;

  oid_content_arc_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] rand_arc();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 127);
    if (r < 7) return $urandom_range(128, 16383);
    if (r < 9) return $urandom_range(16384, 2097151);
    return $urandom;
  endfunction

  // Append one base-128 subidentifier, with optional leading zero groups.
  function automatic void append_subid(logic [63:0] v, int pad);
    int n;
    logic [63:0] grp;
    n = 1;
    while (n < 10 && (v >> (7 * n)) != 0) n++;
    repeat (pad) oid_bytes.push_back(8'h80);
    for (int i = n - 1; i >= 0; i--) begin
      grp = v >> (7 * i);
      oid_bytes.push_back({i != 0, grp[6:0]});
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit st, input bit fin);
    int gap;
    gap = in_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= st;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (sb.note_byte(b, st, fin)) decoded_items++;
    sent_items++;
  endtask

  task automatic send_oid_bytes(input bit with_start, input bit with_final);
    int last_idx;
    last_idx = oid_bytes.size() - 1;
    for (int i = 0; i <= last_idx; i++)
      send_byte(oid_bytes[i], with_start && i == 0, with_final && i == last_idx);
  endtask

  task automatic send_random_oid();
    int flavor;
    int n_more;
    logic [63:0] first_val;
    bit with_start;
    bit with_final;
    oid_bytes.delete();
    flavor     = $urandom_range(0, 99);
    with_start = ($urandom_range(0, 9) != 0);
    with_final = 1'b1;
    if ($urandom_range(0, 19) == 0) in_steady = !in_steady;
    if (flavor < 6) begin
      // raw noise with random marks
      repeat ($urandom_range(1, 8))
        send_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 5) == 0);
      return;
    end
    case ($urandom_range(0, 2))
      0:       first_val = 64'($urandom_range(0, 39));
      1:       first_val = 64'(40 + $urandom_range(0, 39));
      default: first_val = 64'(rand_arc()) + 80;
    endcase
    // padded first subidentifier: bad first arc when it stays below 80
    if (flavor < 12) append_subid(64'($urandom_range(0, 100)), $urandom_range(1, 2));
    else append_subid(first_val, 0);
    n_more = $urandom_range(0, 6);
    repeat (n_more) append_subid(64'(rand_arc()), $urandom_range(0, 15) == 0);
    if (flavor >= 80 && flavor < 84) begin
      oid_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
    end else if (flavor >= 84 && flavor < 88) begin
      append_subid({28'b0, 4'($urandom_range(1, 15)), 32'($urandom)}, 0);
      append_subid(64'(rand_arc()), 0);
    end else if (flavor >= 88 && flavor < 92) begin
      append_subid(64'(rand_arc()), $urandom_range(4, 6));
      append_subid(64'(rand_arc()), 0);
    end else if (flavor >= 92) begin
      with_final = 1'b0;
    end
    send_oid_bytes(with_start, with_final);
  endtask

  initial begin : result_sink
    int stall_left;
    bit steady;
    stall_left = 0;
    steady     = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        sb.check_arc(out_tdata, out_tuser[1:0], out_tlast, out_tuser[2]);
      if ($urandom_range(0, 199) == 0) steady = !steady;
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!steady) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    oid_bytes = '{8'h00};                                     send_oid_bytes(1, 1);
    oid_bytes = '{8'h4f, 8'h28};                              send_oid_bytes(1, 1);
    oid_bytes = '{8'h8f, 8'hff, 8'hff, 8'hff, 8'h7f};         send_oid_bytes(1, 1);
    // multi-byte first subidentifier below 80
    oid_bytes = '{8'h80, 8'h4f};                              send_oid_bytes(1, 1);
    // wider than 32 bits, closed on the final byte
    oid_bytes = '{8'h90, 8'h80, 8'h80, 8'h80, 8'h00};         send_oid_bytes(1, 1);
    // subidentifier too long, then the rest of the OID is skipped
    oid_bytes = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h7f};
    send_oid_bytes(1, 1);
    // OID ends inside a subidentifier
    oid_bytes = '{8'h01, 8'h85};                              send_oid_bytes(1, 1);
    // unfinished OID dropped by the next start
    oid_bytes = '{8'h06, 8'h81};                              send_oid_bytes(1, 0);
    oid_bytes = '{8'h2a, 8'h03};                              send_oid_bytes(1, 1);
    // new OID after a final byte without a start mark
    oid_bytes = '{8'h2a};                                     send_oid_bytes(0, 1);

    while (sent_items < TargetBytes) send_random_oid();
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d content bytes, %0d decoded; checked %0d results in %0d cycles",
             sent_items, decoded_items, sb.checked, cycle_count);
    $display("Arcs %0d, malformed %0d, truncated %0d, bad first arc %0d, mismatches %0d",
             sb.status_seen[ST_ARC], sb.status_seen[ST_MALFORMED],
             sb.status_seen[ST_TRUNCATED], sb.status_seen[ST_BAD_FIRST], sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== oid_content_arc_decoder.f =====
sv/oidca_pkg.sv
sv/oidca_decode.sv
sv/oidca_fifo.sv
sv/oid_content_arc_decoder.sv
tb/sv/tb.sv
